// ===== hdl/ellpt_pkg.sv =====
`default_nettype none

package ellpt_pkg;

  // Pipeline depths of the iterative units.
  localparam int CORDIC_STEPS = 16;
  localparam int SQRT_STEPS   = 32;
  localparam int DIV_STEPS    = 31;

  // Signed width of the CORDIC vector and angle registers.
  localparam int CW = 34;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURN [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // Data that rides along with an item through the whole pipeline.
  typedef struct packed {
    logic               valid;
    logic               zr;     // axis ratio is zero
    logic               deg;    // normalizing length is zero
    logic [1:0]         quad;
    logic [30:0]        rad;
    logic [15:0]        ratio;
    logic [32:0]        minor;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [30:0]        u;
    logic [30:0]        w;
  } side_t;

endpackage

`default_nettype wire

// ===== hdl/ellipse_point_at_polar_angle_unit.sv =====
`default_nettype none

// Channel  Direction  Payload
// s_axis   in         angle, radius, axis_ratio, centre_x, centre_y
// m_axis   out        point_x, point_y
//
// One item is taken per cycle while the output is not stalled; each result
// passes through one fold stage, 16 CORDIC stages, five scaling stages,
// 32 square-root stages, 31 divider stages and two output stages.
// rst is synchronous and clears only the valid bits.
// A stalled output freezes the whole pipeline; nothing is dropped.

module ellipse_point_at_polar_angle_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // angle[15:0], radius[46:16], axis_ratio[62:47], centre_x[94:63],
  // centre_y[126:95], zero[127]
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // point_x[31:0], point_y[63:32]
  output logic [63:0]  m_axis_tdata
);
  import ellpt_pkg::*;

  logic en;

  // Input field unpacking.
  logic [15:0]        angle;
  logic [30:0]        radius;
  logic [15:0]        axis_ratio;
  logic signed [31:0] centre_x;
  logic signed [31:0] centre_y;

  assign angle      = s_axis_tdata[15:0];
  assign radius     = s_axis_tdata[46:16];
  assign axis_ratio = s_axis_tdata[62:47];
  assign centre_x   = s_axis_tdata[94:63];
  assign centre_y   = s_axis_tdata[126:95];

  // The pipeline advances whenever the output register can move.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Fold stage: quadrant, first-quadrant angle and minor semi-axis.
  side_t            s0;
  side_t            s0_next;
  logic signed [CW-1:0] z0;
  logic [14:0]      fold_b;
  logic [46:0]      minor_prod;

  assign fold_b     = angle[14] ? (15'h4000 - {1'b0, angle[13:0]}) : {1'b0, angle[13:0]};
  assign minor_prod = radius * axis_ratio;

  always_comb begin
    s0_next       = '0;
    s0_next.valid = s_axis_tvalid;
    s0_next.zr    = (axis_ratio == '0);
    s0_next.quad  = angle[15:14];
    s0_next.rad   = radius;
    s0_next.ratio = axis_ratio;
    s0_next.minor = minor_prod[46:14];
    s0_next.cx    = centre_x;
    s0_next.cy    = centre_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.valid <= 1'b0;
    end else if (en) begin
      s0 <= s0_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z0 <= $signed({{(CW-31){1'b0}}, fold_b, 16'h0000});
    end
  end

  // Direction of the folded angle.
  side_t                c_side;
  logic signed [CW-1:0] c_x;
  logic signed [CW-1:0] c_y;

  ellpt_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (s0),
    .z_in     (z0),
    .side_out (c_side),
    .x_out    (c_x),
    .y_out    (c_y)
  );

  // Scale the cosine by the axis ratio, after clamping negatives to zero.
  side_t       a_side;
  logic [46:0] a_u;
  logic [46:0] a_w;
  logic [30:0] cl_x;
  logic [30:0] cl_y;

  assign cl_x = (c_x < 0) ? 31'd0 : c_x[30:0];
  assign cl_y = (c_y < 0) ? 31'd0 : c_y[30:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_side.valid <= 1'b0;
    end else if (en) begin
      a_side <= c_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_u <= c_side.ratio * cl_x;
      a_w <= {2'b00, cl_y, 14'h0000};
    end
  end

  // Normalize in two stages: shifts of 16 and 8, then 4, 2 and 1.
  side_t       n1_side;
  logic [46:0] n1_u;
  logic [46:0] n1_w;
  logic [46:0] n1_ua;
  logic [46:0] n1_wa;
  logic [46:0] n1_ub;
  logic [46:0] n1_wb;

  always_comb begin
    n1_ua = a_u;
    n1_wa = a_w;
    if ((a_u[46] | a_w[46]) != 1'b0) begin
      n1_ua = a_u >> 16;
      n1_wa = a_w >> 16;
    end
    n1_ub = n1_ua;
    n1_wb = n1_wa;
    if ((n1_ua[46:38] | n1_wa[46:38]) != '0) begin
      n1_ub = n1_ua >> 8;
      n1_wb = n1_wa >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_side.valid <= 1'b0;
    end else if (en) begin
      n1_side <= a_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_u <= n1_ub;
      n1_w <= n1_wb;
    end
  end

  side_t       n2_side;
  side_t       n2_side_next;
  logic [46:0] n2_ua;
  logic [46:0] n2_wa;
  logic [46:0] n2_ub;
  logic [46:0] n2_wb;
  logic [46:0] n2_uc;
  logic [46:0] n2_wc;

  always_comb begin
    n2_ua = n1_u;
    n2_wa = n1_w;
    if ((n1_u[46:34] | n1_w[46:34]) != '0) begin
      n2_ua = n1_u >> 4;
      n2_wa = n1_w >> 4;
    end
    n2_ub = n2_ua;
    n2_wb = n2_wa;
    if ((n2_ua[46:32] | n2_wa[46:32]) != '0) begin
      n2_ub = n2_ua >> 2;
      n2_wb = n2_wa >> 2;
    end
    n2_uc = n2_ub;
    n2_wc = n2_wb;
    if ((n2_ub[46:31] | n2_wb[46:31]) != '0) begin
      n2_uc = n2_ub >> 1;
      n2_wc = n2_wb >> 1;
    end
    n2_side_next   = n1_side;
    n2_side_next.u = n2_uc[30:0];
    n2_side_next.w = n2_wc[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n2_side.valid <= 1'b0;
    end else if (en) begin
      n2_side <= n2_side_next;
    end
  end

  // Squares, then their sum.
  side_t       q_side;
  logic [61:0] q_uu;
  logic [61:0] q_ww;
  side_t       v_side;
  logic [62:0] v_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_side.valid <= 1'b0;
      v_side.valid <= 1'b0;
    end else if (en) begin
      q_side <= n2_side;
      v_side <= q_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_uu  <= n2_side.u * n2_side.u;
      q_ww  <= n2_side.w * n2_side.w;
      v_sum <= {1'b0, q_uu} + {1'b0, q_ww};
    end
  end

  // Length of the scaled vector.
  side_t       r_side;
  logic [31:0] r_m;

  ellpt_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (v_side),
    .v_in     (v_sum),
    .side_out (r_side),
    .m_out    (r_m)
  );

  // Unit vector (cos t, sin t) in unsigned Q1.30.
  side_t       d_side;
  logic [30:0] d_ct;
  logic [30:0] d_st;

  ellpt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (r_side),
    .m_in     (r_m),
    .side_out (d_side),
    .qu       (d_ct),
    .qw       (d_st)
  );

  // Offsets along both axes.
  side_t       p_side;
  logic [61:0] p_xp;
  logic [63:0] p_yp;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_side.valid <= 1'b0;
    end else if (en) begin
      p_side <= d_side;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xp <= d_side.rad * d_ct;
      p_yp <= d_side.minor * d_st;
    end
  end

  // Round, apply quadrant signs, add the centre and saturate.
  logic [62:0]        rx;
  logic [64:0]        ry;
  logic [35:0]        xo;
  logic [35:0]        yo;
  logic signed [35:0] sx;
  logic signed [35:0] sy;
  logic [31:0]        px;
  logic [31:0]        py;

  assign rx = {1'b0, p_xp} + 63'd536870912;
  assign ry = {1'b0, p_yp} + 65'd536870912;

  always_comb begin
    xo = {3'b000, rx[62:30]};
    yo = {1'b0, ry[64:30]};
    if (p_side.zr || p_side.deg) begin
      xo = '0;
      yo = '0;
    end
    if (p_side.quad[0] ^ p_side.quad[1]) begin
      sx = 36'(p_side.cx) - $signed(xo);
    end else begin
      sx = 36'(p_side.cx) + $signed(xo);
    end
    if (p_side.quad[1]) begin
      sy = 36'(p_side.cy) - $signed(yo);
    end else begin
      sy = 36'(p_side.cy) + $signed(yo);
    end
    if (sx > 36'sd2147483647) begin
      px = 32'h7FFFFFFF;
    end else if (sx < -36'sd2147483648) begin
      px = 32'h80000000;
    end else begin
      px = sx[31:0];
    end
    if (sy > 36'sd2147483647) begin
      py = 32'h7FFFFFFF;
    end else if (sy < -36'sd2147483648) begin
      py = 32'h80000000;
    end else begin
      py = sy[31:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= p_side.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= {py, px};
    end
  end

`ifndef SYNTH
  // An accepted item is captured by the fold stage.
  a_capture: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> s0.valid)
    else $error("accepted item not captured");

  // No component of the normalized vector exceeds one.
  a_unit: assert property (@(posedge clk) disable iff (rst)
    d_side.valid && !d_side.deg |-> d_ct <= 31'h40000000 && d_st <= 31'h40000000)
    else $error("unit vector component above one");

  // A zero axis ratio gives back the centre's x coordinate.
  a_centre: assert property (@(posedge clk) disable iff (rst)
    p_side.valid && p_side.zr && en |=> m_axis_tdata[31:0] == $past(p_side.cx))
    else $error("zero ratio does not return the centre");
`endif

endmodule

`default_nettype wire

// ===== hdl/ellpt_cordic.sv =====
`default_nettype none

module ellpt_cordic (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  ellpt_pkg::side_t             side_in,
  input  logic signed [ellpt_pkg::CW-1:0] z_in,
  output ellpt_pkg::side_t             side_out,
  output logic signed [ellpt_pkg::CW-1:0] x_out,
  output logic signed [ellpt_pkg::CW-1:0] y_out
);
  import ellpt_pkg::*;

  side_t                sd [CORDIC_STEPS+1];
  logic signed [CW-1:0] xs [CORDIC_STEPS+1];
  logic signed [CW-1:0] ys [CORDIC_STEPS+1];
  logic signed [CW-1:0] zs [CORDIC_STEPS+1];

  // The vector starts on the x axis at 2^30; the gain is kept.
  assign sd[0] = side_in;
  assign xs[0] = CW'(64'sd1073741824);
  assign ys[0] = '0;
  assign zs[0] = z_in;

  // One rotation step per register stage.
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] da;

    assign dx = ys[g] >>> g;
    assign dy = xs[g] >>> g;
    assign da = $signed({{(CW-32){1'b0}}, ATAN_TURN[g]});

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[g+1].valid <= 1'b0;
      end else if (en) begin
        sd[g+1] <= sd[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (zs[g] >= 0) begin
          xs[g+1] <= xs[g] - dx;
          ys[g+1] <= ys[g] + dy;
          zs[g+1] <= zs[g] - da;
        end else begin
          xs[g+1] <= xs[g] + dx;
          ys[g+1] <= ys[g] - dy;
          zs[g+1] <= zs[g] + da;
        end
      end
    end
  end

  assign side_out = sd[CORDIC_STEPS];
  assign x_out    = xs[CORDIC_STEPS];
  assign y_out    = ys[CORDIC_STEPS];

endmodule

`default_nettype wire

// ===== hdl/ellpt_isqrt.sv =====
`default_nettype none

module ellpt_isqrt (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ellpt_pkg::side_t side_in,
  input  logic [62:0]      v_in,
  output ellpt_pkg::side_t side_out,
  output logic [31:0]      m_out
);
  import ellpt_pkg::*;

  side_t       sd   [SQRT_STEPS+1];
  logic [63:0] rem  [SQRT_STEPS+1];
  logic [63:0] root [SQRT_STEPS+1];

  assign sd[0]   = side_in;
  assign rem[0]  = {1'b0, v_in};
  assign root[0] = '0;

  // One result bit per stage, testing 4^(31-g) at stage g.
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    logic [63:0] trial;

    assign trial = root[g] + (64'd1 << (62 - 2 * g));

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[g+1].valid <= 1'b0;
      end else if (en) begin
        sd[g+1] <= sd[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[g] >= trial) begin
          rem[g+1]  <= rem[g] - trial;
          root[g+1] <= (root[g] >> 1) + (64'd1 << (62 - 2 * g));
        end else begin
          rem[g+1]  <= rem[g];
          root[g+1] <= root[g] >> 1;
        end
      end
    end
  end

  assign side_out = sd[SQRT_STEPS];
  assign m_out    = root[SQRT_STEPS][31:0];

endmodule

`default_nettype wire

// ===== hdl/ellpt_div.sv =====
`default_nettype none

module ellpt_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  ellpt_pkg::side_t side_in,
  input  logic [31:0]      m_in,
  output ellpt_pkg::side_t side_out,
  output logic [30:0]      qu,
  output logic [30:0]      qw
);
  import ellpt_pkg::*;

  side_t       sd [DIV_STEPS+1];
  logic [31:0] ms [DIV_STEPS+1];
  logic [31:0] ru [DIV_STEPS+1];
  logic [31:0] rw [DIV_STEPS+1];
  logic [30:0] qa [DIV_STEPS+1];
  logic [30:0] qb [DIV_STEPS+1];

  // The quotient of (u << 30) / m stays below 2^31, so the division
  // starts with u >> 1 as the partial remainder.
  always_comb begin
    sd[0]     = side_in;
    sd[0].deg = (m_in == '0);
  end
  assign ms[0] = m_in;
  assign ru[0] = {2'b00, side_in.u[30:1]};
  assign rw[0] = {2'b00, side_in.w[30:1]};
  assign qa[0] = '0;
  assign qb[0] = '0;

  // Two restoring division lanes, one quotient bit per stage.
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
    logic        bu;
    logic        bw;
    logic [32:0] tu;
    logic [32:0] tw;
    logic        ku;
    logic        kw;

    assign bu = (g == 0) ? sd[g].u[0] : 1'b0;
    assign bw = (g == 0) ? sd[g].w[0] : 1'b0;
    assign tu = {ru[g], bu};
    assign tw = {rw[g], bw};
    assign ku = (tu >= {1'b0, ms[g]});
    assign kw = (tw >= {1'b0, ms[g]});

    always_ff @(posedge clk) begin
      if (rst) begin
        sd[g+1].valid <= 1'b0;
      end else if (en) begin
        sd[g+1] <= sd[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ms[g+1] <= ms[g];
        ru[g+1] <= ku ? 32'(tu - {1'b0, ms[g]}) : tu[31:0];
        rw[g+1] <= kw ? 32'(tw - {1'b0, ms[g]}) : tw[31:0];
        qa[g+1] <= {qa[g][29:0], ku};
        qb[g+1] <= {qb[g][29:0], kw};
      end
    end
  end

  assign side_out = sd[DIV_STEPS];
  assign qu       = qa[DIV_STEPS];
  assign qw       = qb[DIV_STEPS];

endmodule

`default_nettype wire
